// File: hw/rtl/glyph_quad_setup_with_clipping_defines.svh
// Assertion macros for the glyph quad setup block.
// Included by gqs_arith and glyph_quad_setup_with_clipping; no other dependencies.
`ifndef GLYPH_QUAD_SETUP_WITH_CLIPPING_DEFINES_SVH
`define GLYPH_QUAD_SETUP_WITH_CLIPPING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gqs assertion failed");
`define GQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gqs assertion failed");
`else
`define GQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/gqs_pkg.sv
// Shared types, widths and helper functions of the glyph quad setup block.
// No dependencies.
package gqs_pkg;

    localparam int POS_W   = 32;
    localparam int MET_W   = 16;
    localparam int TEX_W   = 17;
    localparam int VN_W    = 16;
    localparam int BND_W   = 48;
    localparam int MA_W    = 18;
    localparam int MB_W    = 34;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int DIV_W   = 64;
    localparam int QUO_W   = 17;
    localparam int FIRST_PRINTABLE = 32;
    localparam int FRAC_SHIFT = 12;
    localparam int ADDR_W  = 5;
    localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;

    typedef enum logic [1:0] {
        OP_DRAW    = 2'd0,
        OP_METRICS = 2'd1,
        OP_KERN    = 2'd2,
        OP_ATLAS   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        REG_EM_SIZE   = 3'd0,
        REG_ORIGIN_X  = 3'd1,
        REG_ORIGIN_Y  = 3'd2,
        REG_CLIP_L    = 3'd3,
        REG_CLIP_R    = 3'd4,
        REG_CLIP_B    = 3'd5,
        REG_CLIP_T    = 3'd6,
        REG_SNAP      = 3'd7
    } t_reg;

    typedef struct packed {
        logic                     mul_go;
        logic                     lerp_go;
        logic signed [MA_W-1:0]   a;
        logic signed [MB_W-1:0]   b;
        logic [BND_W-1:0]         num;
        logic [BND_W-1:0]         den;
    } t_arith_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_sts;

    function automatic logic signed [MET_W-1:0] sat16(input logic signed [31:0] x);
        logic signed [MET_W-1:0] r;
        if (x > 32'sd32767) r = 16'sh7FFF;
        else if (x < -32'sd32768) r = 16'sh8000;
        else r = x[MET_W-1:0];
        return r;
    endfunction

    function automatic logic [7:0] clamp_u8(input logic signed [31:0] x);
        logic [7:0] r;
        if (x < 0) r = 8'd0;
        else if (x > 32'sd255) r = 8'd255;
        else r = x[7:0];
        return r;
    endfunction

    function automatic logic [TEX_W-1:0] clamp_tex(input logic signed [31:0] x);
        logic [TEX_W-1:0] r;
        if (x < 0) r = '0;
        else if (x > 32'sd65536) r = TEX_ONE;
        else r = x[TEX_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [BND_W-1:0] x);
        logic signed [POS_W-1:0] r;
        if (x > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (x < -48'sh0000_8000_0000) r = 32'sh8000_0000;
        else r = x[POS_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/gqs_if.sv
// Valid/ready channel interfaces for draw/load items and vertex items.
// Depends on gqs_pkg.
interface gqs_in_if import gqs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic [7:0]              char_code;
    logic                    first_of_string;
    logic [VN_W-1:0]         start_vertex;
    logic [2:0]              kern_slot;
    logic signed [31:0]      value_a;
    logic signed [31:0]      value_b;
    logic signed [31:0]      value_c;
    logic signed [31:0]      value_d;
    modport source (output valid, opcode, char_code, first_of_string, start_vertex,
                    kern_slot, value_a, value_b, value_c, value_d, input ready);
    modport sink   (input valid, opcode, char_code, first_of_string, start_vertex,
                    kern_slot, value_a, value_b, value_c, value_d, output ready);
endinterface

interface gqs_out_if import gqs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [VN_W-1:0]         vertex_number;
    logic [1:0]              corner;
    logic                    last_of_glyph;
    modport source (output valid, pos_x, pos_y, tex_u, tex_v, vertex_number, corner,
                    last_of_glyph, input ready);
    modport sink   (input valid, pos_x, pos_y, tex_u, tex_v, vertex_number, corner,
                    last_of_glyph, output ready);
endinterface

// File: hw/rtl/gqs_arith.sv
// Shared arithmetic unit: one registered 18x34 multiplier, plus texture reinterpolation
// (two partial products, then a 17-step restoring divide). Depends on gqs_pkg and the defines header.
`include "glyph_quad_setup_with_clipping_defines.svh"
module gqs_arith import gqs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_arith_req                i_req,
    output t_arith_sts                o_sts,
    output logic signed [PROD_W-1:0]  o_prod,
    output logic [QUO_W-1:0]          o_quo
);

    typedef enum logic [1:0] {A_IDLE, A_LO, A_HI, A_DIV} t_astate;

    t_astate                  r_state;
    logic signed [MA_W-1:0]   r_a;
    logic [BND_W-1:0]         r_num;
    logic [BND_W-1:0]         r_den;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         r_dsh;
    logic [QUO_W-1:0]         r_q;
    logic [4:0]               r_step;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_done;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] m_prod;
    logic                     ge;

    always_comb begin
        mul_a = i_req.a;
        mul_b = i_req.b;
        unique case (r_state)
            A_LO: begin
                mul_a = r_a;
                mul_b = $signed(MB_W'(r_num[23:0]));
            end
            A_HI: begin
                mul_a = r_a;
                mul_b = $signed(MB_W'(r_num[BND_W-1:24]));
            end
            default: begin
                mul_a = i_req.a;
                mul_b = i_req.b;
            end
        endcase
    end

    assign m_prod = mul_a * mul_b;
    assign ge     = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.mul_go) r_prod <= m_prod;
                    if (i_req.lerp_go) begin
                        r_a     <= i_req.a;
                        r_num   <= i_req.num;
                        r_den   <= i_req.den;
                        r_state <= A_LO;
                    end
                end
                A_LO: begin
                    r_rem   <= $unsigned(DIV_W'(m_prod));
                    r_state <= A_HI;
                end
                A_HI: begin
                    r_rem   <= r_rem + ($unsigned(DIV_W'(m_prod)) << 24);
                    r_dsh   <= DIV_W'(r_den) << (QUO_W - 1);
                    r_step  <= 5'(QUO_W - 1);
                    r_q     <= '0;
                    r_state <= A_DIV;
                end
                A_DIV: begin
                    if (ge) r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[QUO_W-2:0], ge};
                    r_dsh <= r_dsh >> 1;
                    if (r_step == 5'd0) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else begin
                        r_step <= r_step - 5'd1;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_state != A_IDLE);
    assign o_sts.done = r_done;
    assign o_prod     = r_prod;
    assign o_quo      = r_q;

    `GQS_ASSERT_NXT(a_lerp_starts, i_clk, i_rst_n, i_req.lerp_go && !o_sts.busy, o_sts.busy)
    `GQS_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `GQS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == A_IDLE)

endmodule

// File: hw/rtl/glyph_quad_setup_with_clipping.sv
// Top level: config registers, glyph tables and the draw sequencer around gqs_arith.
// One item at a time. Loads write their table on accept. A draw runs check, kern probe, offset,
// extent, advance, test and edge clipping, then sends vertices one per cycle at ready; a hidden
// glyph stops after the test, an unprintable code or degenerate clip at the check. Kerning probes
// slots up to the match or count; a clipped edge runs two multiplier passes, a 17-step divide.
// Synchronous active-low reset clears pen, prev char, vertex count, kern valid flags and config.
`include "glyph_quad_setup_with_clipping_defines.svh"
module glyph_quad_setup_with_clipping import gqs_pkg::*; #(
    parameter int NUM_GLYPHS     = 95,
    parameter int KERN_PER_GLYPH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gqs_in_if.sink               i_in,
    gqs_out_if.source            o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int GW   = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
    localparam int KDEP = NUM_GLYPHS * KERN_PER_GLYPH;
    localparam int KAW  = (KDEP > 1) ? $clog2(KDEP) : 1;
    localparam int KCW  = $clog2(KERN_PER_GLYPH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_KRD, S_KCMP, S_KMUL, S_OFF, S_EXT, S_ADV, S_ADVT,
        S_TEST, S_CLIP, S_CLWAIT, S_OUT, S_FIN
    } t_state;

    // config
    logic signed [31:0] r_em, r_ox, r_oy, r_cl, r_cr, r_cb, r_ct;
    logic               r_snap;

    // tables
    logic [3*MET_W-1:0] r_met_mem [NUM_GLYPHS];
    logic [4*TEX_W-1:0] r_atl_mem [NUM_GLYPHS];
    logic [KCW-1:0]     r_kcnt_mem [NUM_GLYPHS];
    logic [NUM_GLYPHS-1:0] r_kvalid;
    logic [8+MET_W-1:0] r_kern_mem [KDEP];
    logic [3*MET_W-1:0] r_met_rd;
    logic [4*TEX_W-1:0] r_atl_rd;
    logic [KCW-1:0]     r_kcnt_rd;
    logic               r_kval_rd;
    logic [8+MET_W-1:0] r_kern_rd;

    // item and sequencer
    t_state             r_state;
    logic [7:0]         r_code;
    logic               r_first;
    logic [VN_W-1:0]    r_start;
    logic [GW-1:0]      r_g;
    logic               r_print;
    logic [KCW-1:0]     r_kidx;
    logic signed [POS_W-1:0] r_pen;
    logic [7:0]         r_prev;
    logic               r_have_prev;
    logic [VN_W-1:0]    r_vcnt;
    logic signed [BND_W-1:0] r_vl, r_vr, r_advt;
    logic signed [POS_W-1:0] r_xl, r_xr, r_yb, r_yt;
    logic [TEX_W-1:0]   r_ul, r_ur, r_vbt, r_vtp;
    logic [1:0]         r_ci;
    logic [1:0]         r_corner;
    logic               r_ovalid;

    t_arith_req         arq;
    t_arith_sts         ars;
    logic signed [PROD_W-1:0] a_prod;
    logic [QUO_W-1:0]   a_quo;

    gqs_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arq),
        .o_sts   (ars),
        .o_prod  (a_prod),
        .o_quo   (a_quo)
    );

    // input decode
    logic               in_acc;
    logic [7:0]         in_gfull;
    logic               in_print;
    logic [GW-1:0]      in_g;
    logic [KAW-1:0]     in_kaddr;
    logic [KAW-1:0]     rd_kaddr;
    logic signed [31:0] in_cnt_cl;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_gfull = i_in.char_code - 8'(FIRST_PRINTABLE);
    assign in_print = (i_in.char_code >= 8'(FIRST_PRINTABLE)) &&
                      (int'(in_gfull) < NUM_GLYPHS);
    assign in_g     = GW'(in_gfull);
    assign in_kaddr = KAW'(int'(in_g) * KERN_PER_GLYPH + int'(i_in.kern_slot));
    assign rd_kaddr = KAW'(int'(r_g) * KERN_PER_GLYPH + int'(r_kidx));
    assign in_cnt_cl = (i_in.value_c < 0) ? 32'sd0 :
                       (i_in.value_c > KERN_PER_GLYPH) ? 32'(KERN_PER_GLYPH) : i_in.value_c;

    // config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em   <= 32'sh0001_0000;
            r_ox   <= '0;
            r_oy   <= '0;
            r_cl   <= 32'sh8000_0000;
            r_cr   <= 32'sh7FFF_FFFF;
            r_cb   <= 32'sh8000_0000;
            r_ct   <= 32'sh7FFF_FFFF;
            r_snap <= 1'b0;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_EM_SIZE:  r_em   <= pwdata;
                REG_ORIGIN_X: r_ox   <= pwdata;
                REG_ORIGIN_Y: r_oy   <= pwdata;
                REG_CLIP_L:   r_cl   <= pwdata;
                REG_CLIP_R:   r_cr   <= pwdata;
                REG_CLIP_B:   r_cb   <= pwdata;
                REG_CLIP_T:   r_ct   <= pwdata;
                REG_SNAP:     r_snap <= pwdata[0];
                default:      r_snap <= r_snap;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_EM_SIZE:  prdata = r_em;
            REG_ORIGIN_X: prdata = r_ox;
            REG_ORIGIN_Y: prdata = r_oy;
            REG_CLIP_L:   prdata = r_cl;
            REG_CLIP_R:   prdata = r_cr;
            REG_CLIP_B:   prdata = r_cb;
            REG_CLIP_T:   prdata = r_ct;
            REG_SNAP:     prdata = {31'd0, r_snap};
            default:      prdata = '0;
        endcase
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (in_acc && in_print && i_in.opcode == OP_METRICS)
            r_met_mem[in_g] <= {sat16(i_in.value_a), sat16(i_in.value_b),
                                sat16(i_in.value_c)};
        r_met_rd <= r_met_mem[r_g];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_print && i_in.opcode == OP_ATLAS)
            r_atl_mem[in_g] <= {clamp_tex(i_in.value_a), clamp_tex(i_in.value_b),
                                clamp_tex(i_in.value_c), clamp_tex(i_in.value_d)};
        r_atl_rd <= r_atl_mem[r_g];
    end

    logic kern_wr;
    assign kern_wr = in_acc && in_print && (i_in.opcode == OP_KERN) &&
                     (int'(i_in.kern_slot) < KERN_PER_GLYPH);

    always_ff @(posedge i_clk) begin
        if (kern_wr) begin
            r_kern_mem[in_kaddr] <= {clamp_u8(i_in.value_a), sat16(i_in.value_b)};
            r_kcnt_mem[in_g]     <= KCW'(in_cnt_cl);
        end
        r_kern_rd <= r_kern_mem[rd_kaddr];
        r_kcnt_rd <= r_kcnt_mem[r_g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kvalid  <= '0;
            r_kval_rd <= 1'b0;
        end else begin
            if (kern_wr) r_kvalid[in_g] <= 1'b1;
            r_kval_rd <= r_kvalid[r_g];
        end
    end

    // table fields
    logic signed [MET_W-1:0] t_adv, t_off, t_wid, t_koff;
    logic [7:0]              t_kprev;
    logic [KCW-1:0]          t_kcnt;
    logic [TEX_W-1:0]        t_al, t_ar, t_ab, t_at;
    assign {t_adv, t_off, t_wid}  = r_met_rd;
    assign {t_kprev, t_koff}      = r_kern_rd;
    assign {t_al, t_ar, t_ab, t_at} = r_atl_rd;
    assign t_kcnt = r_kval_rd ? r_kcnt_rd : '0;

    // datapath
    logic signed [BND_W-1:0] aem, em_w, ox_w, oy_w, cl_w, cr_w, cb_w, ct_w, pen_w;
    logic signed [BND_W-1:0] prod_t, vt_w, ext_w, pen_adv, pen_rnd, pen_abs;
    logic signed [BND_W-1:0] c_num, c_den;
    logic signed [TEX_W:0]   c_span, c_res;
    logic [TEX_W-1:0]        c_base, c_mag;
    logic                    c_cond, c_neg, degen, visible;
    logic signed [POS_W-1:0] pen_sat;

    assign em_w  = BND_W'(r_em);
    assign aem   = (r_em < 0) ? -em_w : em_w;
    assign ox_w  = BND_W'(r_ox);
    assign oy_w  = BND_W'(r_oy);
    assign cl_w  = BND_W'(r_cl);
    assign cr_w  = BND_W'(r_cr);
    assign cb_w  = BND_W'(r_cb);
    assign ct_w  = BND_W'(r_ct);
    assign pen_w = BND_W'(r_pen);
    assign vt_w  = oy_w + em_w;
    assign prod_t = BND_W'(a_prod >>> FRAC_SHIFT);
    assign ext_w = r_snap ? (prod_t & ~BND_W'(48'hFFFF)) : prod_t;
    assign degen = (r_cr <= r_cl) || (r_ct <= r_cb);
    assign visible = (r_vl < cr_w) && (r_vr > cl_w) && (vt_w > cb_w) && (oy_w < ct_w);

    // pen after advance, then optional round to whole pixel, halves away from zero
    assign pen_sat = sat32(pen_w + r_advt);
    assign pen_abs = (pen_sat < 0) ? -BND_W'(pen_sat) : BND_W'(pen_sat);
    assign pen_adv = (pen_abs + BND_W'(48'h8000)) & ~BND_W'(48'hFFFF);
    assign pen_rnd = (pen_sat < 0) ? -pen_adv : pen_adv;

    always_comb begin
        c_cond = 1'b0;
        c_base = t_ar;
        c_span = '0;
        c_num  = '0;
        c_den  = r_vr - r_vl;
        unique case (r_ci)
            2'd0: begin
                c_cond = r_vl < cl_w;
                c_base = t_ar;
                c_span = $signed({1'b0, t_al}) - $signed({1'b0, t_ar});
                c_num  = r_vr - cl_w;
                c_den  = r_vr - r_vl;
            end
            2'd1: begin
                c_cond = r_vr > cr_w;
                c_base = t_al;
                c_span = $signed({1'b0, t_ar}) - $signed({1'b0, t_al});
                c_num  = cr_w - r_vl;
                c_den  = r_vr - r_vl;
            end
            2'd2: begin
                c_cond = oy_w < cb_w;
                c_base = t_at;
                c_span = $signed({1'b0, t_ab}) - $signed({1'b0, t_at});
                c_num  = vt_w - cb_w;
                c_den  = em_w;
            end
            default: begin
                c_cond = vt_w > ct_w;
                c_base = t_ab;
                c_span = $signed({1'b0, t_at}) - $signed({1'b0, t_ab});
                c_num  = ct_w - oy_w;
                c_den  = em_w;
            end
        endcase
        c_neg = c_span[TEX_W];
        c_mag = c_neg ? TEX_W'(-c_span) : TEX_W'(c_span);
        c_res = c_neg ? $signed({1'b0, c_base}) - $signed({1'b0, a_quo})
                      : $signed({1'b0, c_base}) + $signed({1'b0, a_quo});
    end

    always_comb begin
        arq         = '0;
        arq.num     = $unsigned(c_num);
        arq.den     = $unsigned(c_den);
        unique case (r_state)
            S_KCMP: begin
                arq.mul_go = (r_kidx < t_kcnt) && (t_kprev == r_prev);
                arq.a      = MA_W'(t_koff);
                arq.b      = MB_W'(r_em);
            end
            S_OFF: begin
                arq.mul_go = 1'b1;
                arq.a      = MA_W'(t_off);
                arq.b      = MB_W'(aem);
            end
            S_EXT: begin
                arq.mul_go = 1'b1;
                arq.a      = MA_W'(t_off) + MA_W'(t_wid);
                arq.b      = MB_W'(aem);
            end
            S_ADV: begin
                arq.mul_go = 1'b1;
                arq.a      = MA_W'(t_adv);
                arq.b      = MB_W'(r_em);
            end
            S_CLIP: begin
                arq.lerp_go = c_cond;
                arq.a       = $signed({1'b0, c_mag});
            end
            default: arq.mul_go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pen       <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_vcnt      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_code  <= i_in.char_code;
                        r_first <= i_in.first_of_string;
                        r_start <= i_in.start_vertex;
                        r_g     <= in_g;
                        r_print <= in_print;
                        r_kidx  <= '0;
                        if (i_in.opcode == OP_DRAW) r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (degen) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (r_first) begin
                            r_pen       <= '0;
                            r_have_prev <= 1'b0;
                            r_vcnt      <= r_start;
                        end
                        if (!r_print) begin
                            r_prev      <= r_code;
                            r_have_prev <= 1'b1;
                            r_state     <= S_IDLE;
                        end else if (r_have_prev && !r_first) begin
                            r_state <= S_KRD;
                        end else begin
                            r_state <= S_OFF;
                        end
                    end
                end
                S_KRD: r_state <= S_KCMP;
                S_KCMP: begin
                    if (r_kidx >= t_kcnt) r_state <= S_OFF;
                    else if (t_kprev == r_prev) r_state <= S_KMUL;
                    else begin
                        r_kidx  <= r_kidx + 1'b1;
                        r_state <= S_KRD;
                    end
                end
                S_KMUL: begin
                    r_pen   <= sat32(pen_w + prod_t);
                    r_state <= S_OFF;
                end
                S_OFF: r_state <= S_EXT;
                S_EXT: begin
                    r_vl    <= ox_w + pen_w + prod_t;
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    r_vr    <= ox_w + pen_w + ext_w;
                    r_state <= S_ADVT;
                end
                S_ADVT: begin
                    r_advt  <= prod_t;
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_xl  <= sat32(r_vl);
                    r_xr  <= sat32(r_vr);
                    r_yb  <= r_oy;
                    r_yt  <= sat32(vt_w);
                    r_ul  <= t_al;
                    r_ur  <= t_ar;
                    r_vbt <= t_ab;
                    r_vtp <= t_at;
                    r_ci  <= 2'd0;
                    r_state <= visible ? S_CLIP : S_FIN;
                end
                S_CLIP: begin
                    if (c_cond) r_state <= S_CLWAIT;
                    else if (r_ci == 2'd3) begin
                        r_corner <= 2'd0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else r_ci <= r_ci + 2'd1;
                end
                S_CLWAIT: begin
                    if (ars.done) begin
                        unique case (r_ci)
                            2'd0: begin
                                r_ul <= clamp_tex(32'(c_res));
                                r_xl <= r_cl;
                            end
                            2'd1: begin
                                r_ur <= clamp_tex(32'(c_res));
                                r_xr <= r_cr;
                            end
                            2'd2: begin
                                r_vbt <= clamp_tex(32'(c_res));
                                r_yb  <= r_cb;
                            end
                            default: begin
                                r_vtp <= clamp_tex(32'(c_res));
                                r_yt  <= r_ct;
                            end
                        endcase
                        if (r_ci == 2'd3) begin
                            r_corner <= 2'd0;
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_ci    <= r_ci + 2'd1;
                            r_state <= S_CLIP;
                        end
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        if (r_corner == 2'd3) begin
                            r_ovalid <= 1'b0;
                            r_vcnt   <= r_vcnt + VN_W'(4);
                            r_state  <= S_FIN;
                        end else begin
                            r_corner <= r_corner + 2'd1;
                        end
                    end
                end
                S_FIN: begin
                    r_pen       <= r_snap ? sat32(pen_rnd) : pen_sat;
                    r_prev      <= r_code;
                    r_have_prev <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic left_side, top_side;
    assign left_side = (r_corner == 2'd0) || (r_corner == 2'd1);
    assign top_side  = (r_corner == 2'd0) || (r_corner == 2'd3);

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.pos_x         = left_side ? r_xl : r_xr;
    assign o_out.pos_y         = top_side ? r_yt : r_yb;
    assign o_out.tex_u         = left_side ? r_ul : r_ur;
    assign o_out.tex_v         = top_side ? r_vtp : r_vbt;
    assign o_out.vertex_number = r_vcnt + VN_W'(r_corner);
    assign o_out.corner        = r_corner;
    assign o_out.last_of_glyph = (r_corner == 2'd3);

    `GQS_ASSERT_NXT(a_load_one_cycle, i_clk, i_rst_n, in_acc && (i_in.opcode != OP_DRAW), i_in.ready)
    `GQS_ASSERT_IMP(a_out_blocks_in, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `GQS_ASSERT_NXT(a_quad_end, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.last_of_glyph, r_state == S_FIN)

endmodule

// File: dv/tb_glyph_quad_setup_with_clipping.sv
// Testbench for glyph_quad_setup_with_clipping: random and directed draw/load items,
// APB register phases, and a built-in predictor of the vertex items checked in order.
// Depends on gqs_pkg, gqs_in_if/gqs_out_if and the block itself.
`timescale 1ns / 100ps
module tb_glyph_quad_setup_with_clipping;
    import gqs_pkg::*;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         code;
        logic               first;
        logic [15:0]        sv;
        logic [2:0]         slot;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } t_glyph_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [15:0]        n;
        logic [1:0]         corner;
        logic               last;
    } t_vertex;

    localparam int NG = 95;
    localparam int KPG = 8;
    localparam int DRAIN = 200;
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gqs_in_if  in_ch ();
    gqs_out_if out_ch ();

    t_glyph_item cur_item = '0;
    logic        cur_valid = 0;
    logic        vert_ready = 0;

    assign in_ch.valid           = cur_valid;
    assign in_ch.opcode          = cur_item.op;
    assign in_ch.char_code       = cur_item.code;
    assign in_ch.first_of_string = cur_item.first;
    assign in_ch.start_vertex    = cur_item.sv;
    assign in_ch.kern_slot       = cur_item.slot;
    assign in_ch.value_a         = cur_item.a;
    assign in_ch.value_b         = cur_item.b;
    assign in_ch.value_c         = cur_item.c;
    assign in_ch.value_d         = cur_item.d;
    assign out_ch.ready          = vert_ready;

    glyph_quad_setup_with_clipping DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_glyph_item glyph_feed_q[$];
    t_vertex     vert_due_q[$];
    int          mismatches = 0;
    int          cyc = 0;
    int          stall_cycles = 0;
    logic        quiet;

    assign quiet = (cyc >= 3000 && cyc < 4500);

    // predictor state
    shortint         adv_t[NG], off_t[NG], wid_t[NG];
    int              kcnt_t[NG];
    byte unsigned    kprev_t[NG*KPG];
    shortint         koff_t[NG*KPG];
    longint          atl_t[NG][4];
    longint          pen_x;
    byte unsigned    prev_code;
    bit              have_prev;
    logic [15:0]     vert_count;
    longint          em, org_x, org_y, clip_l, clip_r, clip_b, clip_t;
    bit              snap;

    function automatic longint clampl(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat_pos(longint x);
        return clampl(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint snap_round(longint x);
        longint m;
        m = x < 0 ? -x : x;
        m = (m + 32768) / 65536 * 65536;
        return x < 0 ? -m : m;
    endfunction

    function automatic longint cut_lerp(longint base, longint span, longint num, longint den);
        if (den <= 0) return base;
        return base + span * num / den;
    endfunction

    function automatic void push_vertex(int k, longint x, longint y, longint u, longint v);
        t_vertex w;
        w.x = sat_pos(x);
        w.y = sat_pos(y);
        w.u = clampl(u, 0, 65536);
        w.v = clampl(v, 0, 65536);
        w.n = vert_count + 16'(k);
        w.corner = 2'(k);
        w.last = (k == 3);
        vert_due_q.push_back(w);
    endfunction

    function automatic void apply_glyph_item(t_glyph_item it);
        int g, cnt;
        bit printable;
        longint aem, pen, vl, vr, vb, vt, ext, xl, xr, yb, yt;
        longint al, ar, ab, at, ul, ur, vbt, vtp;
        longint sa, sb, sc, sd;
        printable = it.code >= FIRST_PRINTABLE && it.code < FIRST_PRINTABLE + NG;
        g = printable ? int'(it.code) - FIRST_PRINTABLE : 0;
        sa = it.a; sb = it.b; sc = it.c; sd = it.d;
        case (t_opcode'(it.op))
            OP_METRICS: if (printable) begin
                adv_t[g] = clampl(sa, -32768, 32767);
                off_t[g] = clampl(sb, -32768, 32767);
                wid_t[g] = clampl(sc, -32768, 32767);
            end
            OP_KERN: if (printable) begin
                kprev_t[g*KPG + it.slot] = clampl(sa, 0, 255);
                koff_t[g*KPG + it.slot] = clampl(sb, -32768, 32767);
                kcnt_t[g] = clampl(sc, 0, KPG);
            end
            OP_ATLAS: if (printable) begin
                atl_t[g][0] = clampl(sa, 0, 65536);
                atl_t[g][1] = clampl(sb, 0, 65536);
                atl_t[g][2] = clampl(sc, 0, 65536);
                atl_t[g][3] = clampl(sd, 0, 65536);
            end
            default: begin
                if (clip_r <= clip_l || clip_t <= clip_b) return;
                if (it.first) begin
                    pen_x = 0;
                    have_prev = 0;
                    vert_count = it.sv;
                end
                if (printable) begin
                    aem = em < 0 ? -em : em;
                    pen = pen_x;
                    if (have_prev) begin
                        cnt = kcnt_t[g];
                        for (int i = 0; i < cnt; i++) begin
                            if (kprev_t[g*KPG + i] == prev_code) begin
                                pen = sat_pos(pen + ((longint'(koff_t[g*KPG + i]) * em) >>> 12));
                                break;
                            end
                        end
                    end
                    vl = org_x + pen + ((longint'(off_t[g]) * aem) >>> 12);
                    ext = ((longint'(off_t[g]) + longint'(wid_t[g])) * aem) >>> 12;
                    if (snap) ext = (ext >>> 16) * 65536;
                    vr = org_x + pen + ext;
                    vb = org_y;
                    vt = org_y + em;
                    if (vl < clip_r && vr > clip_l && vt > clip_b && vb < clip_t) begin
                        al = atl_t[g][0]; ar = atl_t[g][1]; ab = atl_t[g][2]; at = atl_t[g][3];
                        xl = vl; xr = vr; yb = vb; yt = vt;
                        ul = al; ur = ar; vbt = ab; vtp = at;
                        if (vl < clip_l) begin
                            ul = cut_lerp(ar, -(ar - al), vr - clip_l, vr - vl);
                            xl = clip_l;
                        end
                        if (vr > clip_r) begin
                            ur = cut_lerp(al, ar - al, clip_r - vl, vr - vl);
                            xr = clip_r;
                        end
                        if (vb < clip_b) begin
                            vbt = cut_lerp(at, -(at - ab), vt - clip_b, vt - vb);
                            yb = clip_b;
                        end
                        if (vt > clip_t) begin
                            vtp = cut_lerp(ab, at - ab, clip_t - vb, vt - vb);
                            yt = clip_t;
                        end
                        push_vertex(0, xl, yt, ul, vtp);
                        push_vertex(1, xl, yb, ul, vbt);
                        push_vertex(2, xr, yb, ur, vbt);
                        push_vertex(3, xr, yt, ur, vtp);
                        vert_count = vert_count + 16'd4;
                    end
                    pen = sat_pos(pen + ((longint'(adv_t[g]) * em) >>> 12));
                    if (snap) pen = sat_pos(snap_round(pen));
                    pen_x = pen;
                end
                prev_code = it.code;
                have_prev = 1;
            end
        endcase
    endfunction

    // stimulus helpers
    byte unsigned glyph_codes[6] = '{8'd32, 8'd65, 8'd86, 8'd97, 8'd105, 8'd126};
    bit [7:0]     kern_written[NG];

    function automatic void queue_item(logic [1:0] op, logic [7:0] code, logic first,
                                       logic [15:0] sv, logic [2:0] slot,
                                       int a, int b, int c, int d);
        t_glyph_item it;
        it = '{op, code, first, sv, slot, a, b, c, d};
        glyph_feed_q.push_back(it);
    endfunction

    // keeps the kern count within the slots loaded so far
    function automatic void queue_kern(logic [7:0] code, logic [2:0] slot, int a, int b, int c);
        int g, k;
        if (code >= 32 && code < 127) begin
            g = code - 32;
            kern_written[g][slot] = 1'b1;
            k = 0;
            while (k < KPG && kern_written[g][k]) k++;
            if (c > k) c = $urandom_range(0, k);
        end
        queue_item(OP_KERN, code, $urandom, $urandom, slot, a, b, c, $urandom);
    endfunction

    function automatic int metric_val();
        return ($urandom_range(0, 4) == 0) ? int'($urandom) : int'($urandom_range(0, 8192)) - 1024;
    endfunction

    function automatic int tex_val();
        return ($urandom_range(0, 4) == 0) ? int'($urandom) : int'($urandom_range(0, 65536));
    endfunction

    function automatic logic [7:0] odd_code();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
    endfunction

    function automatic void queue_random(int n);
        int cnt, len, r;
        logic [7:0] code;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                len = $urandom_range(1, 5);
                for (int j = 0; j < len; j++) begin
                    code = ($urandom_range(0, 7) == 0) ? odd_code() : glyph_codes[$urandom_range(0, 5)];
                    queue_item(OP_DRAW, code, j == 0 || $urandom_range(0, 15) == 0, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom);
                end
                cnt += len;
            end else begin
                code = glyph_codes[$urandom_range(0, 5)];
                case (r)
                    6: queue_item(OP_METRICS, code, $urandom, $urandom, $urandom,
                                  metric_val(), metric_val(), metric_val(), $urandom);
                    7: queue_item(OP_ATLAS, code, $urandom, $urandom, $urandom,
                                  tex_val(), tex_val(), tex_val(), tex_val());
                    8: queue_kern(code, $urandom,
                                  $urandom_range(0, 3) == 0 ? int'($urandom)
                                                            : int'(glyph_codes[$urandom_range(0, 5)]),
                                  $urandom_range(0, 3) == 0 ? int'($urandom)
                                                            : int'($urandom_range(0, 4096)) - 2048,
                                  $urandom_range(0, 3) == 0 ? int'($urandom)
                                                            : int'($urandom_range(0, 9)) - 1);
                    default: queue_item(2'($urandom_range(1, 3)), odd_code(), $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom, $urandom);
                endcase
                cnt++;
            end
        end
    endfunction

    task automatic apb_write(t_reg r, int v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(int'(r) * 4); pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (r)
            REG_EM_SIZE:  em = v;
            REG_ORIGIN_X: org_x = v;
            REG_ORIGIN_Y: org_y = v;
            REG_CLIP_L:   clip_l = v;
            REG_CLIP_R:   clip_r = v;
            REG_CLIP_B:   clip_b = v;
            REG_CLIP_T:   clip_t = v;
            default:      snap = v[0];
        endcase
    endtask

    task automatic wait_idle();
        while (glyph_feed_q.size() != 0 || cur_valid || vert_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic int px(int lo, int hi);
        return ((int'($urandom_range(0, hi - lo)) + lo) <<< 16) + int'($urandom_range(0, 65535));
    endfunction

    task automatic set_phase(int p);
        int ox, oy, cl, cb;
        ox = px(-100, 100);
        oy = px(-100, 100);
        cl = ox + px(-20, 150);
        cb = oy + px(-20, 20);
        case (p)
            1: begin
                apb_write(REG_EM_SIZE, 16 << 16); apb_write(REG_ORIGIN_X, 0);
                apb_write(REG_ORIGIN_Y, 0);
                apb_write(REG_CLIP_L, 32'h8000_0000); apb_write(REG_CLIP_R, 32'h7fff_ffff);
                apb_write(REG_CLIP_B, 32'h8000_0000); apb_write(REG_CLIP_T, 32'h7fff_ffff);
                apb_write(REG_SNAP, 1);
            end
            3: begin
                apb_write(REG_CLIP_L, cl); apb_write(REG_CLIP_R, cl - px(0, 5));
            end
            6: begin
                apb_write(REG_EM_SIZE, 32'h7fff_ffff); apb_write(REG_ORIGIN_X, 32'h8000_0000);
                apb_write(REG_ORIGIN_Y, 32'h7fff_0000);
                apb_write(REG_CLIP_L, 32'h8000_0000); apb_write(REG_CLIP_R, 32'h7fff_ffff);
                apb_write(REG_CLIP_B, 32'h8000_0000); apb_write(REG_CLIP_T, 32'h7fff_ffff);
                apb_write(REG_SNAP, 0);
            end
            7: begin
                apb_write(REG_EM_SIZE, 32'h8000_0000); apb_write(REG_ORIGIN_X, 32'h7fff_ffff);
                apb_write(REG_ORIGIN_Y, 32'h8000_0000);
                apb_write(REG_CLIP_B, 32'h7fff_fffe);
                apb_write(REG_SNAP, 1);
            end
            default: begin
                apb_write(REG_EM_SIZE, ($urandom_range(0, 4) == 0 ? -1 : 1) * px(4, 40));
                apb_write(REG_ORIGIN_X, ox); apb_write(REG_ORIGIN_Y, oy);
                apb_write(REG_CLIP_L, cl); apb_write(REG_CLIP_R, cl + px(1, 60));
                apb_write(REG_CLIP_B, cb); apb_write(REG_CLIP_T, cb + px(1, 30));
                apb_write(REG_SNAP, $urandom_range(0, 1));
            end
        endcase
    endtask

    initial begin
        kcnt_t = '{default: 0};
        pen_x = 0; prev_code = 0; have_prev = 0; vert_count = 0;
        em = 65536; org_x = 0; org_y = 0;
        clip_l = -64'sd2147483648; clip_r = 64'sd2147483647;
        clip_b = -64'sd2147483648; clip_t = 64'sd2147483647;
        snap = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: table loads with field extremes, kerning, unprintable and wrap cases
        queue_item(OP_METRICS, 32, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
        queue_item(OP_METRICS, 65, 0, 0, 0, 2048, 0, 2048, 0);
        queue_item(OP_METRICS, 86, 0, 0, 0, 2300, -200, 2600, 0);
        queue_item(OP_METRICS, 97, 0, 0, 0, 1900, 100, 1700, 0);
        queue_item(OP_METRICS, 105, 0, 0, 0, 900, 150, 600, 0);
        queue_item(OP_METRICS, 126, 0, 0, 0, 2200, -32768, 32767, -1);
        queue_item(OP_METRICS, 127, 1, 16'hffff, 7, 1, 1, 1, 1);
        queue_item(OP_ATLAS, 32, 0, 0, 0, -5, 32'h7fff_ffff, 32'h8000_0000, 65536);
        for (int i = 1; i < 6; i++)
            queue_item(OP_ATLAS, glyph_codes[i], 0, 0, 0, i * 4000, i * 4000 + 3000, 100, 9000);
        queue_kern(86, 0, 65, -300, 1);
        queue_kern(86, 1, 300, 32'h8000_0000, 2);
        queue_kern(10, 7, -1, 32767, 100);
        queue_item(OP_DRAW, 65, 1, 0, 0, 0, 0, 0, 0);
        queue_item(OP_DRAW, 86, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_DRAW, 10, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_DRAW, 86, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_DRAW, 255, 0, 0, 0, -1, -1, -1, -1);
        queue_item(OP_DRAW, 126, 1, 16'hfffe, 7, 0, 0, 0, 0);
        queue_item(OP_DRAW, 32, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_DRAW, 105, 0, 0, 0, 0, 0, 0, 0);
        queue_random(6);

        for (int p = 1; p <= 7; p++) begin
            wait_idle();
            set_phase(p);
            queue_random(p == 3 ? 8 : 16);
        end
        wait_idle();
        if (mismatches == 0 && vert_due_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_valid <= 0;
        end else if (!cur_valid || in_ch.ready) begin
            if (glyph_feed_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
                cur_item <= glyph_feed_q.pop_front();
                cur_valid <= 1;
            end else begin
                cur_valid <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) vert_ready <= 0;
        else vert_ready <= quiet || ($urandom_range(0, 99) >= 26);
    end

    // predictor on input accept, checker on vertex accept, watchdog
    always @(posedge i_clk) begin
        t_vertex exp_v;
        cyc <= cyc + 1;
        if (i_rst_n && cur_valid && in_ch.ready) apply_glyph_item(cur_item);
        if (i_rst_n && out_ch.valid && vert_ready) begin
            if (vert_due_q.size() == 0) begin
                if (mismatches < 10) $display("unexpected vertex item n=%0d", out_ch.vertex_number);
                mismatches++;
            end else begin
                exp_v = vert_due_q.pop_front();
                if (out_ch.pos_x !== exp_v.x || out_ch.pos_y !== exp_v.y ||
                    out_ch.tex_u !== exp_v.u || out_ch.tex_v !== exp_v.v ||
                    out_ch.vertex_number !== exp_v.n || out_ch.corner !== exp_v.corner ||
                    out_ch.last_of_glyph !== exp_v.last) begin
                    if (mismatches < 10)
                        $display("vertex mismatch: exp x=%0d y=%0d u=%0d v=%0d n=%0d c=%0d l=%0d | got x=%0d y=%0d u=%0d v=%0d n=%0d c=%0d l=%0d",
                                 exp_v.x, exp_v.y, exp_v.u, exp_v.v, exp_v.n, exp_v.corner,
                                 exp_v.last, out_ch.pos_x, out_ch.pos_y, out_ch.tex_u,
                                 out_ch.tex_v, out_ch.vertex_number, out_ch.corner,
                                 out_ch.last_of_glyph);
                    mismatches++;
                end
            end
        end
        if ((cur_valid && in_ch.ready) || (out_ch.valid && vert_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/gqs_pkg.sv
hw/rtl/gqs_if.sv
hw/rtl/gqs_arith.sv
hw/rtl/glyph_quad_setup_with_clipping.sv
dv/tb_glyph_quad_setup_with_clipping.sv
